FILE: sv/omni_base_motor_ramp_assert.svh
// assertion macros for the omni base motor ramp
`ifndef OMNI_BASE_MOTOR_RAMP_ASSERT_SVH
`define OMNI_BASE_MOTOR_RAMP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OBMR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define OBMR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/obmr_pkg.sv
// types, constants and ramp functions for the omni base motor ramp
package obmr_pkg;

	localparam logic [17:0] COEF_DIAG    = 18'd46341;
	localparam logic [17:0] COEF_DEG2RAD = 18'd1144;

	localparam logic [15:0] SPEED_CAP_RST  = 16'd1000;
	localparam logic [7:0]  SPEED_STEP_RST = 8'd10;
	localparam logic [7:0]  WHEEL_ARM_RST  = 8'd16;

	localparam logic [1:0] REG_SPEED_CAP  = 2'd0;
	localparam logic [1:0] REG_SPEED_STEP = 2'd1;
	localparam logic [1:0] REG_WHEEL_ARM  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_ABS,
		ST_CMP,
		ST_CAP,
		ST_ML0,
		ST_ML1,
		ST_ML2,
		ST_DIV,
		ST_DR_INIT,
		ST_DR,
		ST_DL_INIT,
		ST_DL,
		ST_RAMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       stopped;
		logic       cw;
	} set_st_t;

	function automatic logic [7:0] ramp_duty(logic [7:0] tgt, logic [7:0] prev,
		logic [7:0] step);
		logic [7:0] diff;
		logic       full;
		logic [7:0] res;
		diff = (prev > tgt) ? (prev - tgt) : (tgt - prev);
		full = diff > step;
		if (tgt == 8'd0) begin
			res = full ? (prev - step) : 8'd0;
		end else if (prev > tgt) begin
			res = full ? (prev - step) : tgt;
		end else begin
			res = full ? (prev + step) : tgt;
		end
		return res;
	endfunction

	function automatic set_st_t run_set(set_st_t cur, logic [7:0] tgt, logic want_cw,
		logic [7:0] step);
		set_st_t    nxt;
		logic [7:0] d;
		nxt = cur;
		d   = ramp_duty(8'd0, cur.duty, step);
		if (cur.stopped) begin
			if (tgt != 8'd0) begin
				nxt.stopped = 1'b0;
				nxt.cw      = want_cw;
				nxt.duty    = ramp_duty(tgt, cur.duty, step);
			end
		end else if ((want_cw == cur.cw) && (tgt != 8'd0)) begin
			nxt.duty = ramp_duty(tgt, cur.duty, step);
		end else begin
			nxt.duty = d;
			if (d == 8'd0) begin
				nxt.stopped = 1'b1;
			end
		end
		return nxt;
	endfunction

endpackage

FILE: sv/omni_base_motor_ramp.sv
// omni base motor ramp: wheel speeds, cap, duty map and per-set ramp
//
// one input item per control tick on s_*: vel_x, vel_y, vel_w (signed).
// one result item per input on m_*: both set duties, latched directions
// and stopped flags. registers speed cap, speed step and wheel arm are
// written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// an item runs through a sequencer around one shared 25x18 multiplier and
// one shared restoring divide step (one quotient bit per cycle). when the
// speeds are capped, an item also passes the multiply and set-up states
// ML0, ML1, ML2 and 16 divide steps. s_tready is high only when idle, so
// one item is in flight at a time: a new item is taken only after the
// previous result has been taken by the receiver on m_tready.
// the result is held in registers with m_tvalid high until m_tready; no new
// item is taken meanwhile. reset restores the register defaults, zero
// duties, both sets stopped and latched direction counter-clockwise.
`include "omni_base_motor_ramp_assert.svh"

module omni_base_motor_ramp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // vel_x, vel_y, vel_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // duty_right_set, duty_left_set, right_set_cw,
	                               // left_set_cw, right_set_stopped, left_set_stopped, pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	obmr_pkg::state_t state_q, state_nx;

	logic [15:0] speed_cap_q;
	logic [7:0]  speed_step_q;
	logic [7:0]  wheel_arm_q;
	obmr_pkg::set_st_t right_q, left_q;

	logic [15:0] vx_q, vy_q, vw_q;
	logic signed [35:0] prod_q, ang_q, sr_q, sl_q;
	logic [33:0] ar_q, al_q, big_q, small_q;
	logic        cw_r_q, cw_l_q, left_big_q;
	logic [49:0] acc_q;
	logic [15:0] ir_q, il_q;
	logic [7:0]  tr_q, tl_q;
	logic [33:0] rem_q, dsor_q;
	logic [15:0] dlow_q, quo_q;
	logic [3:0]  cnt_q;

	logic [15:0] m_eff;
	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [42:0] mul_p;
	logic [16:0] dif_yx;
	logic [17:0] sum_xy, neg_sum;
	logic [35:0] sr_neg, sl_neg;
	logic        cap_hit;
	logic [34:0] div_shl, div_trial;
	logic        div_take;
	logic [15:0] div_qnx;
	logic [49:0] cap_dvd;
	logic [23:0] dr_dvd, dl_dvd;

	assign m_eff   = (speed_cap_q == 16'd0) ? 16'd1 : speed_cap_q;
	assign dif_yx  = {vy_q[15], vy_q} - {vx_q[15], vx_q};
	assign sum_xy  = {{2{vx_q[15]}}, vx_q} + {{2{vy_q[15]}}, vy_q};
	assign neg_sum = 18'd0 - sum_xy;
	assign sr_neg  = -sr_q;
	assign sl_neg  = -sl_q;
	assign cap_hit = big_q > {2'b00, m_eff, 16'h0000};
	assign mul_p   = mul_a * mul_b;

	assign div_shl   = {rem_q, dlow_q[15]};
	assign div_trial = div_shl - {1'b0, dsor_q};
	assign div_take  = !div_trial[34];
	assign div_qnx   = {quo_q[14:0], div_take};

	assign cap_dvd = acc_q + {prod_q[32:0], 17'd0};
	assign dr_dvd  = {ir_q, 8'd0} - {8'd0, ir_q};
	assign dl_dvd  = {il_q, 8'd0} - {8'd0, il_q};

	always_comb begin
		unique case (state_q)
			obmr_pkg::ST_M0: begin
				mul_a = {{9{vw_q[15]}}, vw_q};
				mul_b = {10'd0, wheel_arm_q};
			end
			obmr_pkg::ST_M1: begin
				mul_a = prod_q[24:0];
				mul_b = obmr_pkg::COEF_DEG2RAD;
			end
			obmr_pkg::ST_M2: begin
				mul_a = {{8{dif_yx[16]}}, dif_yx};
				mul_b = obmr_pkg::COEF_DIAG;
			end
			obmr_pkg::ST_M3: begin
				mul_a = {{7{neg_sum[17]}}, neg_sum};
				mul_b = obmr_pkg::COEF_DIAG;
			end
			obmr_pkg::ST_ML0: begin
				mul_a = {8'd0, small_q[16:0]};
				mul_b = {2'b00, m_eff};
			end
			obmr_pkg::ST_ML1: begin
				mul_a = {8'd0, small_q[33:17]};
				mul_b = {2'b00, m_eff};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			obmr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nx = obmr_pkg::ST_M0;
				end
			end
			obmr_pkg::ST_M0:  state_nx = obmr_pkg::ST_M1;
			obmr_pkg::ST_M1:  state_nx = obmr_pkg::ST_M2;
			obmr_pkg::ST_M2:  state_nx = obmr_pkg::ST_M3;
			obmr_pkg::ST_M3:  state_nx = obmr_pkg::ST_M4;
			obmr_pkg::ST_M4:  state_nx = obmr_pkg::ST_ABS;
			obmr_pkg::ST_ABS: state_nx = obmr_pkg::ST_CMP;
			obmr_pkg::ST_CMP: state_nx = obmr_pkg::ST_CAP;
			obmr_pkg::ST_CAP: begin
				state_nx = cap_hit ? obmr_pkg::ST_ML0 : obmr_pkg::ST_DR_INIT;
			end
			obmr_pkg::ST_ML0: state_nx = obmr_pkg::ST_ML1;
			obmr_pkg::ST_ML1: state_nx = obmr_pkg::ST_ML2;
			obmr_pkg::ST_ML2: state_nx = obmr_pkg::ST_DIV;
			obmr_pkg::ST_DIV: begin
				if (cnt_q == 4'd0) begin
					state_nx = obmr_pkg::ST_DR_INIT;
				end
			end
			obmr_pkg::ST_DR_INIT: state_nx = obmr_pkg::ST_DR;
			obmr_pkg::ST_DR: begin
				if (cnt_q == 4'd0) begin
					state_nx = obmr_pkg::ST_DL_INIT;
				end
			end
			obmr_pkg::ST_DL_INIT: state_nx = obmr_pkg::ST_DL;
			obmr_pkg::ST_DL: begin
				if (cnt_q == 4'd0) begin
					state_nx = obmr_pkg::ST_RAMP;
				end
			end
			obmr_pkg::ST_RAMP: state_nx = obmr_pkg::ST_OUT;
			obmr_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_nx = obmr_pkg::ST_IDLE;
				end
			end
			default: state_nx = obmr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration and per-set ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_cap_q  <= obmr_pkg::SPEED_CAP_RST;
			speed_step_q <= obmr_pkg::SPEED_STEP_RST;
			wheel_arm_q  <= obmr_pkg::WHEEL_ARM_RST;
			right_q      <= '{duty: 8'd0, stopped: 1'b1, cw: 1'b0};
			left_q       <= '{duty: 8'd0, stopped: 1'b1, cw: 1'b0};
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					obmr_pkg::REG_SPEED_CAP:  speed_cap_q  <= cfg_data;
					obmr_pkg::REG_SPEED_STEP: speed_step_q <= cfg_data[7:0];
					obmr_pkg::REG_WHEEL_ARM:  wheel_arm_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (state_q == obmr_pkg::ST_RAMP) begin
				right_q <= obmr_pkg::run_set(right_q, tr_q, cw_r_q, speed_step_q);
				left_q  <= obmr_pkg::run_set(left_q, tl_q, cw_l_q, speed_step_q);
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			obmr_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					vx_q <= s_tdata[15:0];
					vy_q <= s_tdata[31:16];
					vw_q <= s_tdata[47:32];
				end
			end
			obmr_pkg::ST_M0: prod_q <= mul_p[35:0];
			obmr_pkg::ST_M1: prod_q <= mul_p[35:0];
			obmr_pkg::ST_M2: begin
				ang_q  <= prod_q;
				prod_q <= mul_p[35:0];
			end
			obmr_pkg::ST_M3: begin
				sr_q   <= prod_q + ang_q;
				prod_q <= mul_p[35:0];
			end
			obmr_pkg::ST_M4: sl_q <= prod_q + ang_q;
			obmr_pkg::ST_ABS: begin
				cw_r_q <= sr_q[35];
				cw_l_q <= sl_q[35];
				ar_q   <= sr_q[35] ? sr_neg[33:0] : sr_q[33:0];
				al_q   <= sl_q[35] ? sl_neg[33:0] : sl_q[33:0];
			end
			obmr_pkg::ST_CMP: begin
				left_big_q <= al_q > ar_q;
				big_q      <= (al_q > ar_q) ? al_q : ar_q;
				small_q    <= (al_q > ar_q) ? ar_q : al_q;
			end
			obmr_pkg::ST_CAP: begin
				ir_q <= ar_q[31:16];
				il_q <= al_q[31:16];
			end
			obmr_pkg::ST_ML0: prod_q <= mul_p[35:0];
			obmr_pkg::ST_ML1: begin
				acc_q  <= {17'd0, prod_q[32:0]};
				prod_q <= mul_p[35:0];
			end
			obmr_pkg::ST_ML2: begin
				rem_q  <= cap_dvd[49:16];
				dlow_q <= cap_dvd[15:0];
				dsor_q <= big_q;
				cnt_q  <= 4'd15;
			end
			obmr_pkg::ST_DIV, obmr_pkg::ST_DR, obmr_pkg::ST_DL: begin
				rem_q  <= div_take ? div_trial[33:0] : div_shl[33:0];
				dlow_q <= {dlow_q[14:0], 1'b0};
				quo_q  <= div_qnx;
				cnt_q  <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					if (state_q == obmr_pkg::ST_DIV) begin
						ir_q <= left_big_q ? div_qnx : m_eff;
						il_q <= left_big_q ? m_eff : div_qnx;
					end else if (state_q == obmr_pkg::ST_DR) begin
						tr_q <= div_qnx[7:0];
					end else begin
						tl_q <= div_qnx[7:0];
					end
				end
			end
			obmr_pkg::ST_DR_INIT: begin
				rem_q  <= {18'd0, dr_dvd[23:8]};
				dlow_q <= {dr_dvd[7:0], 8'd0};
				dsor_q <= {18'd0, m_eff};
				cnt_q  <= 4'd7;
			end
			obmr_pkg::ST_DL_INIT: begin
				rem_q  <= {18'd0, dl_dvd[23:8]};
				dlow_q <= {dl_dvd[7:0], 8'd0};
				dsor_q <= {18'd0, m_eff};
				cnt_q  <= 4'd7;
			end
			obmr_pkg::ST_RAMP: ;
			obmr_pkg::ST_OUT: ;
			default: ;
		endcase
	end

	assign m_tdata = {4'd0, left_q.stopped, right_q.stopped, left_q.cw, right_q.cw,
		left_q.duty, right_q.duty};

	`OBMR_ASSERT_IMP(a_hs_excl, m_tvalid, !s_tready, "ready while result pending")
	`OBMR_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready && !m_tvalid, "not busy after accept")
	`OBMR_ASSERT_IMP(a_right_stop_zero, right_q.stopped, right_q.duty == 8'd0, "right set stopped with duty")
	`OBMR_ASSERT_IMP(a_left_stop_zero, left_q.stopped, left_q.duty == 8'd0, "left set stopped with duty")

endmodule
